>>> hw/rtl/cpr_pkg.sv
// Shared types and constants for the calibrated point rescaler.
// Used by the channel interfaces and by the core; depends on nothing else.
package cpr_pkg;

  localparam int COORD_BITS = 12;
  localparam int OUT_BITS   = 16;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [OUT_BITS-1:0] screen_t;

  // Configuration register map.
  localparam int CFG_COUNT    = 8;
  localparam int CFG_IDX_BITS = $clog2(CFG_COUNT);
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam int REG_ORIGIN_X      = 0;
  localparam int REG_ORIGIN_Y      = 1;
  localparam int REG_RIGHT_X       = 2;
  localparam int REG_BOTTOM_Y      = 3;
  localparam int REG_CAMERA_WIDTH  = 4;
  localparam int REG_CAMERA_HEIGHT = 5;
  localparam int REG_SCREEN_WIDTH  = 6;
  localparam int REG_SCREEN_HEIGHT = 7;

  localparam coord_t CFG_RESET [CFG_COUNT] = '{
    COORD_BITS'(0), COORD_BITS'(0), COORD_BITS'(1023), COORD_BITS'(767),
    COORD_BITS'(1024), COORD_BITS'(768), COORD_BITS'(1920), COORD_BITS'(1080)
  };

  // Magnitude widths: offset times camera size, then times screen size.
  localparam int Q1_BITS = 2 * COORD_BITS;
  localparam int Q2_BITS = 3 * COORD_BITS;
  localparam int MAG_BITS = ((Q2_BITS > OUT_BITS) ? Q2_BITS : OUT_BITS) + 1;

  // Input register, first product, divider one, second product, divider two, output.
  localparam int PIPE_DEPTH = Q1_BITS + Q2_BITS + 4;
  localparam int ST_P1      = 1;
  localparam int ST_D1      = 2;
  localparam int ST_P2      = Q1_BITS + 2;
  localparam int ST_D2      = Q1_BITS + 3;
  localparam int ST_OUT     = PIPE_DEPTH - 1;

  localparam logic [MAG_BITS-1:0] POS_LIMIT = (MAG_BITS'(1) << (OUT_BITS - 1)) - MAG_BITS'(1);
  localparam logic [MAG_BITS-1:0] NEG_LIMIT = MAG_BITS'(1) << (OUT_BITS - 1);

endpackage

>>> hw/rtl/cpr_point_if.sv
// Input channel carrying one camera point per request.
// Depends on cpr_pkg.
interface cpr_point_if import cpr_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;

  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

>>> hw/rtl/cpr_result_if.sv
// Result channel carrying one mapped screen point per request.
// Depends on cpr_pkg.
interface cpr_result_if import cpr_pkg::*; ();
  logic    valid;
  logic    ready;
  screen_t screen_x;
  screen_t screen_y;
  logic    span_error;
  logic    saturated;

  modport source (output valid, screen_x, screen_y, span_error, saturated, input ready);
  modport sink   (input valid, screen_x, screen_y, span_error, saturated, output ready);
endinterface

>>> hw/rtl/cpr_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on cpr_pkg.
interface cpr_cfg_if import cpr_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  coord_t   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/calibrated_point_rescaler_core.sv
// Calibrated point rescaler core: two-stage linear camera-to-screen mapping.
// Depends on cpr_pkg, cpr_point_if, cpr_result_if and cpr_cfg_if.
//
//   channel   direction  contents
//   in_chan   sink       point_x, point_y
//   out_chan  source     screen_x, screen_y, span_error, saturated
//   cfg_chan  sink       index, data (always ready)
//
// One request enters per cycle unless the pipeline is stalled;
// the two restoring dividers retire one quotient bit per stage.
// The whole pipeline advances when the output register is empty or being taken,
// so a stall holds every stage, bubbles included.
// rst_n clears the valid bits and loads the configuration defaults.
module calibrated_point_rescaler_core import cpr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  cpr_point_if.sink     in_chan,
  cpr_result_if.source  out_chan,
  cpr_cfg_if.sink       cfg_chan
);

  coord_t cfg_r [CFG_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_chan.valid) begin
      cfg_r[cfg_chan.index] <= cfg_chan.data;
    end
  end

  assign cfg_chan.ready = 1'b1;

  logic       v_r   [PIPE_DEPTH];
  logic       err_r [PIPE_DEPTH];
  logic [1:0] neg_r [PIPE_DEPTH];
  logic       en;
  logic       err_in;
  logic [1:0] neg_in;
  logic [1:0] zero_div;

  logic [Q2_BITS-1:0] mag   [2];
  screen_t            res   [2];
  logic [1:0]         clamp;

  assign en            = out_chan.ready | ~v_r[ST_OUT];
  assign in_chan.ready = en;
  assign err_in        = |zero_div;

  for (genvar a = 0; a < 2; a++) begin : g_lane
    coord_t                   org;
    coord_t                   corner;
    coord_t                   cam;
    coord_t                   scr;
    coord_t                   pt;
    logic signed [COORD_BITS:0] off;
    logic signed [COORD_BITS:0] span;
    coord_t                   span_mag;
    coord_t                   off_mag_r;
    logic [Q1_BITS-1:0]       p1_r;
    logic [Q1_BITS-1:0]       d1_dq_r  [Q1_BITS];
    coord_t                   d1_rem_r [Q1_BITS-1];
    logic [Q2_BITS-1:0]       p2_r;
    logic [Q2_BITS-1:0]       d2_dq_r  [Q2_BITS];
    coord_t                   d2_rem_r [Q2_BITS-1];
    logic [MAG_BITS-1:0]      mag_ext;
    screen_t                  mag_low;

    assign org    = cfg_r[REG_ORIGIN_X + a];
    assign corner = cfg_r[REG_RIGHT_X + a];
    assign cam    = cfg_r[REG_CAMERA_WIDTH + a];
    assign scr    = cfg_r[REG_SCREEN_WIDTH + a];
    assign pt     = (a == 0) ? in_chan.point_x : in_chan.point_y;

    // User must keep configuration quiet while requests are in flight; unchecked, read live.
    assign span     = $signed({1'b0, corner}) - $signed({1'b0, org});
    assign span_mag = span[COORD_BITS] ? COORD_BITS'(-span) : COORD_BITS'(span);
    assign off      = $signed({1'b0, pt}) - $signed({1'b0, org});
    assign neg_in[a]   = off[COORD_BITS] ^ span[COORD_BITS];
    assign zero_div[a] = (span == '0) || (cam == '0);

    always_ff @(posedge clk) begin
      if (en) begin
        off_mag_r <= off[COORD_BITS] ? COORD_BITS'(-off) : COORD_BITS'(off);
        p1_r      <= Q1_BITS'(off_mag_r * cam);
        p2_r      <= Q2_BITS'(d1_dq_r[Q1_BITS-1] * scr);
      end
    end

    // Divider one: |offset| * camera size / |span|, one quotient bit per stage.
    for (genvar k = 0; k < Q1_BITS; k++) begin : g_d1
      logic [Q1_BITS-1:0] dq_in;
      coord_t             rem_in;
      logic [COORD_BITS:0] sh;
      logic               take;
      if (k == 0) begin : g_first
        assign dq_in  = p1_r;
        assign rem_in = '0;
      end else begin : g_next
        assign dq_in  = d1_dq_r[k-1];
        assign rem_in = d1_rem_r[k-1];
      end
      assign sh   = {rem_in, dq_in[Q1_BITS-1]};
      assign take = sh >= {1'b0, span_mag};
      always_ff @(posedge clk) begin
        if (en) begin
          d1_dq_r[k] <= {dq_in[Q1_BITS-2:0], take};
        end
      end
      if (k < Q1_BITS - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            d1_rem_r[k] <= take ? COORD_BITS'(sh - {1'b0, span_mag}) : sh[COORD_BITS-1:0];
          end
        end
      end
    end

    // Divider two: first quotient * screen size / camera size.
    for (genvar k = 0; k < Q2_BITS; k++) begin : g_d2
      logic [Q2_BITS-1:0] dq_in;
      coord_t             rem_in;
      logic [COORD_BITS:0] sh;
      logic               take;
      if (k == 0) begin : g_first
        assign dq_in  = p2_r;
        assign rem_in = '0;
      end else begin : g_next
        assign dq_in  = d2_dq_r[k-1];
        assign rem_in = d2_rem_r[k-1];
      end
      assign sh   = {rem_in, dq_in[Q2_BITS-1]};
      assign take = sh >= {1'b0, cam};
      always_ff @(posedge clk) begin
        if (en) begin
          d2_dq_r[k] <= {dq_in[Q2_BITS-2:0], take};
        end
      end
      if (k < Q2_BITS - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            d2_rem_r[k] <= take ? COORD_BITS'(sh - {1'b0, cam}) : sh[COORD_BITS-1:0];
          end
        end
      end
    end

    assign mag[a]  = d2_dq_r[Q2_BITS-1];
    assign mag_ext = MAG_BITS'(mag[a]);
    assign mag_low = OUT_BITS'(mag_ext);

    // The sign is applied to the magnitude only after the range check.
    always_comb begin
      clamp[a] = 1'b0;
      res[a]   = neg_r[ST_OUT-1][a] ? -mag_low : mag_low;
      if (neg_r[ST_OUT-1][a]) begin
        if (mag_ext > NEG_LIMIT) begin
          clamp[a] = 1'b1;
          res[a]   = -OUT_BITS'(NEG_LIMIT);
        end
      end else if (mag_ext > POS_LIMIT) begin
        clamp[a] = 1'b1;
        res[a]   = OUT_BITS'(POS_LIMIT);
      end
    end
  end

  // Control bits travel alongside the data in every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_chan.valid;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err_r[0] <= err_in;
      neg_r[0] <= neg_in;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        err_r[i] <= err_r[i-1];
        neg_r[i] <= neg_r[i-1];
      end
    end
  end

  screen_t screen_x_r;
  screen_t screen_y_r;
  logic    saturated_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (err_r[ST_OUT-1]) begin
        screen_x_r  <= '0;
        screen_y_r  <= '0;
        saturated_r <= 1'b0;
      end else begin
        screen_x_r  <= res[0];
        screen_y_r  <= res[1];
        saturated_r <= |clamp;
      end
    end
  end

  assign out_chan.valid      = v_r[ST_OUT];
  assign out_chan.screen_x   = screen_x_r;
  assign out_chan.screen_y   = screen_y_r;
  assign out_chan.span_error = err_r[ST_OUT];
  assign out_chan.saturated  = saturated_r;

endmodule

>>> verif/cpr_scoreboard.sv
// Checker for the calibrated point rescaler: it watches the point, result and
// configuration channels and predicts every screen point. Depends on cpr_pkg and the interfaces.
module cpr_scoreboard import cpr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  cpr_point_if    pt,
  cpr_result_if   res,
  cpr_cfg_if      cfg,
  output int      fail_count,
  output int      pending
);

  typedef struct packed {
    screen_t sx;
    screen_t sy;
    logic    err;
    logic    sat;
  } screen_point_t;

  screen_point_t expected_points[$];
  coord_t        cal_regs [CFG_COUNT];

  localparam longint SCREEN_MAX = (longint'(1) <<< (OUT_BITS - 1)) - 1;
  localparam longint SCREEN_MIN = -SCREEN_MAX - 1;

  // Both stages truncate toward zero, which SystemVerilog signed division does too.
  function automatic longint two_stage(longint off, longint span, longint cam, longint scr);
    longint t;
    t = (off * cam) / span;
    return (t * scr) / cam;
  endfunction

  function automatic screen_point_t map_point(coord_t x, coord_t y);
    screen_point_t p;
    longint span_x, span_y, cw, ch, rx, ry;
    span_x = longint'(cal_regs[REG_RIGHT_X]) - longint'(cal_regs[REG_ORIGIN_X]);
    span_y = longint'(cal_regs[REG_BOTTOM_Y]) - longint'(cal_regs[REG_ORIGIN_Y]);
    cw = longint'(cal_regs[REG_CAMERA_WIDTH]);
    ch = longint'(cal_regs[REG_CAMERA_HEIGHT]);
    p = '0;
    if (span_x == 0 || span_y == 0 || cw == 0 || ch == 0) begin
      p.err = 1'b1;
    end else begin
      rx = two_stage(longint'(x) - longint'(cal_regs[REG_ORIGIN_X]), span_x, cw,
                     longint'(cal_regs[REG_SCREEN_WIDTH]));
      ry = two_stage(longint'(y) - longint'(cal_regs[REG_ORIGIN_Y]), span_y, ch,
                     longint'(cal_regs[REG_SCREEN_HEIGHT]));
      if (rx > SCREEN_MAX) begin rx = SCREEN_MAX; p.sat = 1'b1; end
      if (rx < SCREEN_MIN) begin rx = SCREEN_MIN; p.sat = 1'b1; end
      if (ry > SCREEN_MAX) begin ry = SCREEN_MAX; p.sat = 1'b1; end
      if (ry < SCREEN_MIN) begin ry = SCREEN_MIN; p.sat = 1'b1; end
      p.sx = screen_t'(rx);
      p.sy = screen_t'(ry);
    end
    return p;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    cal_regs = CFG_RESET;
  end

  always @(posedge clk) begin
    screen_point_t want, got;
    if (!rst_n) begin
      cal_regs = CFG_RESET;
    end else begin
      if (cfg.valid && cfg.ready) cal_regs[cfg.index] = cfg.data;
      if (pt.valid && pt.ready) expected_points.push_back(map_point(pt.point_x, pt.point_y));
      if (res.valid && res.ready) begin
        got = '{res.screen_x, res.screen_y, res.span_error, res.saturated};
        if (expected_points.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result x=%0d y=%0d err=%b sat=%b",
                     got.sx, got.sy, got.err, got.sat);
        end else begin
          want = expected_points.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected x=%0d y=%0d err=%b sat=%b, got x=%0d y=%0d err=%b sat=%b",
                       want.sx, want.sy, want.err, want.sat,
                       got.sx, got.sy, got.err, got.sat);
          end
        end
      end
      pending = expected_points.size();
    end
  end

endmodule

>>> verif/calibrated_point_rescaler_core_tb.sv
// Testbench top for the calibrated point rescaler core: drives points and
// calibration writes under varying backpressure.
// Depends on cpr_pkg, the interfaces and cpr_scoreboard.
module calibrated_point_rescaler_core_tb;
  import cpr_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   snd_idle = 0;
  int   rcv_idle = 0;
  logic hold_request = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   fail_count, pending;

  cpr_point_if  pt_if();
  cpr_result_if res_if();
  cpr_cfg_if    cfg_if();

  calibrated_point_rescaler_core dut (
    .clk(clk), .rst_n(rst_n), .in_chan(pt_if), .out_chan(res_if), .cfg_chan(cfg_if)
  );

  cpr_scoreboard checker_i (
    .clk(clk), .rst_n(rst_n), .pt(pt_if), .res(res_if), .cfg(cfg_if),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    pt_if.valid = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    res_if.ready = 1'b0;
  end

  // Result side: random idling, plus one long hold-off so the pipeline fills up.
  always @(negedge clk) begin
    if (hold_request && !hold_done) begin
      hold_left = 400;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Called at a falling edge; returns at a falling edge.
  task automatic send_point(coord_t x, coord_t y);
    while ($urandom_range(99) < snd_idle) begin
      pt_if.valid <= 1'b0;
      @(negedge clk);
    end
    pt_if.valid <= 1'b1;
    pt_if.point_x <= x;
    pt_if.point_y <= y;
    do @(posedge clk); while (!pt_if.ready);
    @(negedge clk);
  endtask

  // Leaves valid high; the caller drops it after the last write.
  task automatic write_reg(cfg_idx_t idx, coord_t val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
  endtask

  // Wait until every request has come back, then let the pipeline settle.
  task automatic drain();
    pt_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 8) @(negedge clk);
  endtask

  task automatic calibrate(coord_t ox, coord_t oy, coord_t rx, coord_t by,
                           coord_t cw, coord_t ch, coord_t sw, coord_t sh);
    drain();
    write_reg(cfg_idx_t'(REG_ORIGIN_X), ox);
    write_reg(cfg_idx_t'(REG_ORIGIN_Y), oy);
    write_reg(cfg_idx_t'(REG_RIGHT_X), rx);
    write_reg(cfg_idx_t'(REG_BOTTOM_Y), by);
    write_reg(cfg_idx_t'(REG_CAMERA_WIDTH), cw);
    write_reg(cfg_idx_t'(REG_CAMERA_HEIGHT), ch);
    write_reg(cfg_idx_t'(REG_SCREEN_WIDTH), sw);
    write_reg(cfg_idx_t'(REG_SCREEN_HEIGHT), sh);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic coord_t pick_coord(coord_t near);
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return near;
      3: return near + coord_t'($urandom_range(3)) - coord_t'(2);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coord_t pick_size();
    case ($urandom_range(9))
      0: return '0;
      1: return coord_t'(1);
      2: return '1;
      3, 4: return coord_t'($urandom_range(64, 1));
      default: return coord_t'($urandom);
    endcase
  endfunction

  initial begin
    coord_t ox, oy;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Default calibration: corners and extremes of the point fields.
    send_point('0, '0);
    send_point('1, '1);
    send_point('0, '1);
    send_point('1, '0);
    send_point(coord_t'(1023), coord_t'(767));
    send_point(coord_t'(1024), coord_t'(768));
    // Corners left of and above the origin give negative spans; points before it too.
    calibrate(coord_t'(3000), coord_t'(2000), coord_t'(100), coord_t'(50),
              coord_t'(640), coord_t'(480), coord_t'(800), coord_t'(600));
    send_point('0, '0);
    send_point('1, '1);
    send_point(coord_t'(3000), coord_t'(2000));
    send_point(coord_t'(2999), coord_t'(2001));
    // Zero camera width suppresses both axes.
    calibrate('0, '0, coord_t'(100), coord_t'(100), '0, coord_t'(5), '1, '1);
    send_point(coord_t'(50), coord_t'(50));
    send_point('1, '1);
    // Zero span.
    calibrate(coord_t'(7), coord_t'(9), coord_t'(7), coord_t'(100), '1, '1, '1, '1);
    send_point(coord_t'(8), coord_t'(10));
    // Unit span with a wide screen saturates in both directions.
    calibrate(coord_t'(2048), coord_t'(2048), coord_t'(2049), coord_t'(2047),
              coord_t'(1), '1, '1, '1);
    send_point('1, '0);
    send_point('0, '1);
    send_point(coord_t'(2048), coord_t'(2048));
    send_point(coord_t'(2049), coord_t'(2049));
    // Everything at its top value.
    calibrate('1, '1, '1, '1, '1, '1, '1, '1);
    send_point('0, '0);
    send_point('1, '1);

    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 0) calibrate('0, '0, '1, '1, '1, '1, '1, '1);
      else if (phase == 1) calibrate('1, '1, '0, '0, coord_t'(1), coord_t'(1), '0, '0);
      else calibrate(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                     coord_t'($urandom), pick_size(), pick_size(), pick_size(), pick_size());
      if (phase < 4) begin snd_idle = 23; rcv_idle = 83; end
      else if (phase < 7) begin snd_idle = 83; rcv_idle = 23; end
      else begin snd_idle = 0; rcv_idle = 0; end
      ox = checker_i.cal_regs[REG_ORIGIN_X];
      oy = checker_i.cal_regs[REG_ORIGIN_Y];
      for (int n = 0; n < 170; n++) begin
        if (phase == 8 && n == 10) begin
          pt_if.valid <= 1'b0;
          @(posedge clk);
          hold_request = 1'b1;
          @(negedge clk);
        end
        send_point(pick_coord(ox), pick_coord(oy));
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/cpr_pkg.sv
hw/rtl/cpr_point_if.sv
hw/rtl/cpr_result_if.sv
hw/rtl/cpr_cfg_if.sv
hw/rtl/calibrated_point_rescaler_core.sv
verif/cpr_scoreboard.sv
verif/calibrated_point_rescaler_core_tb.sv
